// ===== design/plane_from_three_points_defines.svh =====
// Assertion macros for the plane-from-three-points block.
// Included by the top level; needs clk_i and rst_ni in the including scope.
`ifndef PLANE_FROM_THREE_POINTS_DEFINES_SVH
`define PLANE_FROM_THREE_POINTS_DEFINES_SVH
`ifndef SYNTHESIS
`define PFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PFP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define PFP_ASSERT(lbl, prop, msg)
`define PFP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== design/pfp_pkg.sv =====
// Shared constants for the plane-from-three-points block.
// No dependencies.
package pfp_pkg;
  localparam int unsigned NORM_W  = 31;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned SUMSQ_W = 64;
  localparam int unsigned QUOT_W  = 31;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned FRAC_SH = 30;
endpackage

// ===== design/pfp_if.sv =====
// Request and response channel interfaces of the plane block.
// Depends on pfp_pkg for the result width.
interface pfp_req_if #(parameter int unsigned COORD_WIDTH = 24) ();
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] point_a_x, point_a_y, point_a_z;
  logic signed [COORD_WIDTH-1:0] point_b_x, point_b_y, point_b_z;
  logic signed [COORD_WIDTH-1:0] point_c_x, point_c_y, point_c_z;
  modport source (output valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
                  point_b_z, point_c_x, point_c_y, point_c_z, input ready);
  modport sink (input valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
                point_b_z, point_c_x, point_c_y, point_c_z, output ready);
endinterface

interface pfp_rsp_if ();
  logic valid;
  logic ready;
  logic signed [pfp_pkg::OUT_W-1:0] normal_x, normal_y, normal_z, plane_offset;
  logic degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, plane_offset, degenerate,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, plane_offset, degenerate,
                output ready);
endinterface

// ===== design/pfp_cross.sv =====
// Edge vectors and exact cross product, three register stages.
// No package dependencies.
module pfp_cross #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [COORD_WIDTH-1:0]        pa_i [3],
  input  logic signed [COORD_WIDTH-1:0]        pb_i [3],
  input  logic signed [COORD_WIDTH-1:0]        pc_i [3],
  output logic                                 valid_o,
  output logic signed [2*COORD_WIDTH+2:0]      cross_o [3],
  output logic signed [COORD_WIDTH-1:0]        pa_o [3]
);
  localparam int unsigned EW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned CW = PW + 1;

  logic [2:0] vld_q;
  logic signed [EW-1:0] eu_q [3];
  logic signed [EW-1:0] ew_q [3];
  logic signed [PW-1:0] prod_q [6];
  logic signed [CW-1:0] cross_q [3];
  logic signed [COORD_WIDTH-1:0] pa_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        eu_q[k] <= {pb_i[k][COORD_WIDTH-1], pb_i[k]} - {pa_i[k][COORD_WIDTH-1], pa_i[k]};
        ew_q[k] <= {pc_i[k][COORD_WIDTH-1], pc_i[k]} - {pa_i[k][COORD_WIDTH-1], pa_i[k]};
      end
      prod_q[0] <= eu_q[1] * ew_q[2];
      prod_q[1] <= eu_q[2] * ew_q[1];
      prod_q[2] <= eu_q[2] * ew_q[0];
      prod_q[3] <= eu_q[0] * ew_q[2];
      prod_q[4] <= eu_q[0] * ew_q[1];
      prod_q[5] <= eu_q[1] * ew_q[0];
      for (int k = 0; k < 3; k++) begin
        cross_q[k] <= {prod_q[2*k][PW-1], prod_q[2*k]}
                    - {prod_q[2*k+1][PW-1], prod_q[2*k+1]};
      end
      pa_q[0] <= pa_i;
      pa_q[1] <= pa_q[0];
      pa_q[2] <= pa_q[1];
    end
  end

  assign valid_o = vld_q[2];
  assign cross_o = cross_q;
  assign pa_o    = pa_q[2];
endmodule

// ===== design/pfp_norm.sv =====
// Magnitudes, leading-one search, normalizing shift and sum of squares.
// Five register stages; depends on pfp_pkg.
module pfp_norm #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [2*COORD_WIDTH+2:0]      cross_i [3],
  input  logic signed [COORD_WIDTH-1:0]        pa_i [3],
  output logic                                 valid_o,
  output logic                                 deg_o,
  output logic [2:0]                           neg_o,
  output logic [pfp_pkg::NORM_W-1:0]           sm_o [3],
  output logic [pfp_pkg::SUMSQ_W-1:0]          sumsq_o,
  output logic signed [COORD_WIDTH-1:0]        pa_o [3]
);
  localparam int unsigned CW  = 2 * COORD_WIDTH + 3;
  localparam int unsigned NW  = pfp_pkg::NORM_W;
  localparam int unsigned SHW = $clog2(CW + 1);
  localparam int unsigned SQW = 2 * NW;

  logic [4:0] vld_q;
  logic [2:0] neg_q [5];
  logic signed [COORD_WIDTH-1:0] pa_q [5][3];
  logic [3:0] deg_q;
  logic [CW-1:0] mag_q [3];
  logic [CW-1:0] mag5_q [3];
  logic [SHW-1:0] shift_q;
  logic [NW-1:0] sm_q [3][3];
  logic [SQW-1:0] sq_q [3];
  logic [pfp_pkg::SUMSQ_W-1:0] sumsq_q;

  logic [CW-1:0] orv;
  logic [SHW-1:0] topb;
  logic [CW+NW-1:0] wide [3];

  always_comb begin
    orv  = mag_q[0] | mag_q[1] | mag_q[2];
    topb = '0;
    for (int i = 0; i < CW; i++) begin
      if (orv[i]) begin
        topb = SHW'(i + 1);
      end
    end
    for (int k = 0; k < 3; k++) begin
      wide[k] = {mag5_q[k], {NW{1'b0}}} << shift_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        neg_q[0][k] <= cross_i[k][CW-1];
        mag_q[k]    <= cross_i[k][CW-1] ? CW'(-cross_i[k]) : CW'(cross_i[k]);
      end
      pa_q[0] <= pa_i;
      for (int s = 1; s < 5; s++) begin
        neg_q[s] <= neg_q[s-1];
        pa_q[s]  <= pa_q[s-1];
      end
      mag5_q   <= mag_q;
      shift_q  <= SHW'(CW) - topb;
      deg_q[0] <= (orv == '0);
      for (int s = 1; s < 4; s++) begin
        deg_q[s] <= deg_q[s-1];
      end
      for (int k = 0; k < 3; k++) begin
        sm_q[0][k] <= wide[k][CW+NW-1 -: NW];
        sq_q[k]    <= sm_q[0][k] * sm_q[0][k];
      end
      sm_q[1] <= sm_q[0];
      sm_q[2] <= sm_q[1];
      sumsq_q <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    end
  end

  assign valid_o = vld_q[4];
  assign deg_o   = deg_q[3];
  assign neg_o   = neg_q[4];
  assign sm_o    = sm_q[2];
  assign sumsq_o = sumsq_q;
  assign pa_o    = pa_q[4];
endmodule

// ===== design/pfp_sqrt.sv =====
// Integer square root of the sum of squares, one result bit per stage.
// Depends on pfp_pkg.
module pfp_sqrt #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic                                 deg_i,
  input  logic [2:0]                           neg_i,
  input  logic [pfp_pkg::NORM_W-1:0]           sm_i [3],
  input  logic [pfp_pkg::SUMSQ_W-1:0]          sumsq_i,
  input  logic signed [COORD_WIDTH-1:0]        pa_i [3],
  output logic                                 valid_o,
  output logic                                 deg_o,
  output logic [2:0]                           neg_o,
  output logic [pfp_pkg::NORM_W-1:0]           sm_o [3],
  output logic [pfp_pkg::LEN_W-1:0]            len_o,
  output logic signed [COORD_WIDTH-1:0]        pa_o [3]
);
  localparam int unsigned STEPS = pfp_pkg::LEN_W;
  localparam int unsigned XW    = pfp_pkg::SUMSQ_W;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] r;
  } sq_t;

  function automatic sq_t sqrt_step(sq_t s, int unsigned i);
    sq_t o;
    logic [XW-1:0] b;
    logic [XW-1:0] t;
    b = XW'(1) << (XW - 2 - 2 * i);
    t = s.r + b;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  logic [STEPS-1:0] vld_q;
  logic [STEPS-1:0] deg_q;
  logic [2:0] neg_q [STEPS];
  logic [pfp_pkg::NORM_W-1:0] sm_q [STEPS][3];
  logic signed [COORD_WIDTH-1:0] pa_q [STEPS][3];
  sq_t st_q [STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= sqrt_step('{x: sumsq_i, r: '0}, 0);
      deg_q[0] <= deg_i;
      neg_q[0] <= neg_i;
      sm_q[0]  <= sm_i;
      pa_q[0]  <= pa_i;
      for (int unsigned i = 1; i < STEPS; i++) begin
        st_q[i]  <= sqrt_step(st_q[i-1], i);
        deg_q[i] <= deg_q[i-1];
        neg_q[i] <= neg_q[i-1];
        sm_q[i]  <= sm_q[i-1];
        pa_q[i]  <= pa_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign deg_o   = deg_q[STEPS-1];
  assign neg_o   = neg_q[STEPS-1];
  assign sm_o    = sm_q[STEPS-1];
  assign len_o   = st_q[STEPS-1].r[pfp_pkg::LEN_W-1:0];
  assign pa_o    = pa_q[STEPS-1];
endmodule

// ===== design/pfp_div.sv =====
// Rounded quotient m * 2^30 / L for the three components, restoring divider
// with one quotient bit per stage. Depends on pfp_pkg.
module pfp_div #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic                                 deg_i,
  input  logic [2:0]                           neg_i,
  input  logic [pfp_pkg::NORM_W-1:0]           sm_i [3],
  input  logic [pfp_pkg::LEN_W-1:0]            len_i,
  input  logic signed [COORD_WIDTH-1:0]        pa_i [3],
  output logic                                 valid_o,
  output logic                                 deg_o,
  output logic [2:0]                           neg_o,
  output logic [pfp_pkg::QUOT_W-1:0]           quot_o [3],
  output logic signed [COORD_WIDTH-1:0]        pa_o [3]
);
  localparam int unsigned LW    = pfp_pkg::LEN_W;
  localparam int unsigned QW    = pfp_pkg::QUOT_W;
  localparam int unsigned NUMW  = pfp_pkg::NORM_W + pfp_pkg::FRAC_SH + 1;
  localparam int unsigned STEPS = QW + 1;

  typedef struct packed {
    logic [LW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] q;
  } dv_t;

  function automatic dv_t div_step(dv_t s, logic [LW-1:0] len);
    dv_t o;
    logic [LW:0] t;
    t     = {s.rem, s.low[QW-1]};
    o.low = {s.low[QW-2:0], 1'b0};
    if (t >= {1'b0, len}) begin
      o.rem = LW'(t - {1'b0, len});
      o.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      o.rem = t[LW-1:0];
      o.q   = {s.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [STEPS-1:0] vld_q;
  logic [STEPS-1:0] deg_q;
  logic [2:0] neg_q [STEPS];
  logic [LW-1:0] len_q [STEPS];
  logic signed [COORD_WIDTH-1:0] pa_q [STEPS][3];
  dv_t dv_q [STEPS][3];
  logic [NUMW-1:0] num [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {sm_i[k], {pfp_pkg::FRAC_SH{1'b0}}} + NUMW'(len_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dv_q[0][k] <= '{rem: LW'(num[k][NUMW-1:QW]), low: num[k][QW-1:0], q: '0};
      end
      deg_q[0] <= deg_i;
      neg_q[0] <= neg_i;
      len_q[0] <= len_i;
      pa_q[0]  <= pa_i;
      for (int i = 1; i < STEPS; i++) begin
        for (int k = 0; k < 3; k++) begin
          dv_q[i][k] <= div_step(dv_q[i-1][k], len_q[i-1]);
        end
        deg_q[i] <= deg_q[i-1];
        neg_q[i] <= neg_q[i-1];
        len_q[i] <= len_q[i-1];
        pa_q[i]  <= pa_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign deg_o   = deg_q[STEPS-1];
  assign neg_o   = neg_q[STEPS-1];
  assign pa_o    = pa_q[STEPS-1];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quot_o[k] = dv_q[STEPS-1][k].q;
    end
  end
endmodule

// ===== design/plane_from_three_points.sv =====
// Plane through three points: unit normal (Q1.30) and offset (Q19.12).
// Depends on pfp_pkg, pfp_if, pfp_cross, pfp_norm, pfp_sqrt, pfp_div.
//
// A request on req_i carries three points with signed Q11.12 coordinates.
// One response on rsp_o follows for every request, in order: the unit
// normal of the plane, the offset d = -(normal . a) and a degenerate flag,
// set with all other fields zero when the points are collinear.
// From an accepted request to a valid response, a request passes through
// the cross product, scaling and the sum of squares, the square root (one
// bit per stage), the divider (setup plus one quotient bit per stage) and
// the sign, offset and output register. While the pipeline is not stalled,
// a new request is taken in every cycle, so throughput is one per cycle.
// The whole pipeline advances together: while a response waits on rsp_o
// and the receiver holds ready low, every stage holds and req_i.ready is
// low. Reset clears all valid bits; no response is pending afterward.
`include "plane_from_three_points_defines.svh"
module plane_from_three_points #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfp_req_if.sink    req_i,
  pfp_rsp_if.source  rsp_o
);
  localparam int unsigned OW  = pfp_pkg::OUT_W;
  localparam int unsigned CW  = 2 * COORD_WIDTH + 3;
  localparam int unsigned PRW = OW + COORD_WIDTH;
  localparam int unsigned AW  = PRW + 2;
  localparam logic signed [AW:0] RoundBias =
    {{(AW - pfp_pkg::FRAC_SH + 1){1'b0}}, 1'b1, {(pfp_pkg::FRAC_SH - 1){1'b0}}};
  localparam logic signed [AW:0] DMax = {{(AW - OW + 2){1'b0}}, {(OW - 1){1'b1}}};
  localparam logic signed [AW:0] DMin = {{(AW - OW + 2){1'b1}}, {(OW - 1){1'b0}}};

  logic en;
  logic signed [COORD_WIDTH-1:0] pa_in [3];
  logic signed [COORD_WIDTH-1:0] pb_in [3];
  logic signed [COORD_WIDTH-1:0] pc_in [3];

  logic cr_valid;
  logic signed [CW-1:0] cr_cross [3];
  logic signed [COORD_WIDTH-1:0] cr_pa [3];

  logic nm_valid, nm_deg;
  logic [2:0] nm_neg;
  logic [pfp_pkg::NORM_W-1:0] nm_sm [3];
  logic [pfp_pkg::SUMSQ_W-1:0] nm_sumsq;
  logic signed [COORD_WIDTH-1:0] nm_pa [3];

  logic sq_valid, sq_deg;
  logic [2:0] sq_neg;
  logic [pfp_pkg::NORM_W-1:0] sq_sm [3];
  logic [pfp_pkg::LEN_W-1:0] sq_len;
  logic signed [COORD_WIDTH-1:0] sq_pa [3];

  logic dv_valid, dv_deg;
  logic [2:0] dv_neg;
  logic [pfp_pkg::QUOT_W-1:0] dv_quot [3];
  logic signed [COORD_WIDTH-1:0] dv_pa [3];

  logic [2:0] vld_q;
  logic [2:0] deg_q;
  logic signed [OW-1:0] nrm_q [3][3];
  logic signed [COORD_WIDTH-1:0] pa_q [3];
  logic signed [PRW-1:0] prod_q [3];
  logic signed [AW-1:0] acc_q;
  logic rsp_valid_q;
  logic signed [OW-1:0] nx_q, ny_q, nz_q, off_q;
  logic deg_out_q;

  logic signed [AW:0] tneg;
  logic signed [AW:0] dsh;
  logic signed [OW-1:0] off_d;

  assign en          = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  assign pa_in = '{req_i.point_a_x, req_i.point_a_y, req_i.point_a_z};
  assign pb_in = '{req_i.point_b_x, req_i.point_b_y, req_i.point_b_z};
  assign pc_in = '{req_i.point_c_x, req_i.point_c_y, req_i.point_c_z};

  pfp_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req_i.valid),
    .pa_i(pa_in), .pb_i(pb_in), .pc_i(pc_in),
    .valid_o(cr_valid), .cross_o(cr_cross), .pa_o(cr_pa)
  );

  pfp_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cr_valid), .cross_i(cr_cross), .pa_i(cr_pa),
    .valid_o(nm_valid), .deg_o(nm_deg), .neg_o(nm_neg), .sm_o(nm_sm),
    .sumsq_o(nm_sumsq), .pa_o(nm_pa)
  );

  pfp_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(nm_valid), .deg_i(nm_deg), .neg_i(nm_neg),
    .sm_i(nm_sm), .sumsq_i(nm_sumsq), .pa_i(nm_pa),
    .valid_o(sq_valid), .deg_o(sq_deg), .neg_o(sq_neg), .sm_o(sq_sm),
    .len_o(sq_len), .pa_o(sq_pa)
  );

  pfp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid), .deg_i(sq_deg), .neg_i(sq_neg),
    .sm_i(sq_sm), .len_i(sq_len), .pa_i(sq_pa),
    .valid_o(dv_valid), .deg_o(dv_deg), .neg_o(dv_neg), .quot_o(dv_quot), .pa_o(dv_pa)
  );

  always_comb begin
    tneg = -$signed({acc_q[AW-1], acc_q}) + RoundBias;
    dsh  = tneg >>> pfp_pkg::FRAC_SH;
    if (dsh > DMax) begin
      off_d = DMax[OW-1:0];
    end else if (dsh < DMin) begin
      off_d = DMin[OW-1:0];
    end else begin
      off_d = dsh[OW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[1:0], dv_valid};
      rsp_valid_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nrm_q[0][k] <= dv_neg[k] ? -$signed({1'b0, dv_quot[k]}) : $signed({1'b0, dv_quot[k]});
        prod_q[k]   <= nrm_q[0][k] * pa_q[k];
      end
      nrm_q[1] <= nrm_q[0];
      nrm_q[2] <= nrm_q[1];
      pa_q     <= dv_pa;
      deg_q    <= {deg_q[1:0], dv_deg};
      acc_q    <= {{2{prod_q[0][PRW-1]}}, prod_q[0]} + {{2{prod_q[1][PRW-1]}}, prod_q[1]}
                + {{2{prod_q[2][PRW-1]}}, prod_q[2]};
      deg_out_q <= deg_q[2];
      if (deg_q[2]) begin
        nx_q  <= '0;
        ny_q  <= '0;
        nz_q  <= '0;
        off_q <= '0;
      end else begin
        nx_q  <= nrm_q[2][0];
        ny_q  <= nrm_q[2][1];
        nz_q  <= nrm_q[2][2];
        off_q <= off_d;
      end
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.normal_x     = nx_q;
  assign rsp_o.normal_y     = ny_q;
  assign rsp_o.normal_z     = nz_q;
  assign rsp_o.plane_offset = off_q;
  assign rsp_o.degenerate   = deg_out_q;

  `PFP_ASSERT(a_deg_zero, !(rsp_o.valid && rsp_o.degenerate) || (rsp_o.normal_x == 0 && rsp_o.normal_y == 0 && rsp_o.normal_z == 0 && rsp_o.plane_offset == 0), "degenerate response has nonzero fields")
  `PFP_ASSERT(a_unit_range, !(rsp_o.valid && !rsp_o.degenerate) || (rsp_o.normal_x <= 32'sh40000000 && rsp_o.normal_x >= -32'sh40000000 && rsp_o.normal_z <= 32'sh40000000 && rsp_o.normal_z >= -32'sh40000000), "normal component exceeds one")
  `PFP_ASSERT(a_nonzero, !(rsp_o.valid && !rsp_o.degenerate) || rsp_o.normal_x != 0 || rsp_o.normal_y != 0 || rsp_o.normal_z != 0, "normal of a proper plane is zero")
  `PFP_ASSERT(a_stall, !(rsp_o.valid && !rsp_o.ready) || !req_i.ready, "request taken while stalled")
  `PFP_ASSERT_NEXT(a_hold, rsp_o.valid && !rsp_o.ready, rsp_o.valid && $stable(rsp_o.normal_x) && $stable(rsp_o.plane_offset), "held response changed")
endmodule
